// ----- rtl/dq_pkg.sv -----
// Shared types and codes for the double-ended queue.
package dq_pkg;

  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_POP_FRONT  = 2'd1,
    OP_PUSH_BACK  = 2'd2,
    OP_POP_BACK   = 2'd3
  } dq_op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } dq_status_t;

  // One-cycle command broadcast to every cell.
  typedef struct packed {
    logic push_front;
    logic pop_front;
    logic push_back;
    logic pop_back;
  } dq_cmd_t;

  typedef struct packed {
    dq_status_t         status;
    logic               popped_valid;
    logic [DATA_W-1:0]  popped_value;
    logic [OCC_W-1:0]   occupancy;
  } dq_res_t;

endpackage

// ----- rtl/dq_cell.sv -----
// One storage cell of the shifting deque chain.
module dq_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  dq_pkg::dq_cmd_t           cmd,
  input  logic [dq_pkg::DATA_W-1:0] push_value,
  input  logic [dq_pkg::DATA_W-1:0] left_data,
  input  logic                      left_occ,
  input  logic [dq_pkg::DATA_W-1:0] right_data,
  input  logic                      right_occ,
  output logic [dq_pkg::DATA_W-1:0] data,
  output logic                      occ,
  output logic                      last
);
  import dq_pkg::*;

  logic [DATA_W-1:0] data_next;
  logic              occ_next;

  // Back of the queue: occupied, right neighbor empty.
  assign last = occ && !right_occ;

  // commands are one-hot or all low; all low holds the cell
  always_comb begin
    data_next = data;
    occ_next  = occ;
    if (cmd.push_front) begin
      data_next = left_data;
      occ_next  = left_occ;
    end else if (cmd.pop_front) begin
      data_next = right_data;
      occ_next  = right_occ;
    end else if (cmd.push_back) begin
      if (!occ && left_occ) begin
        data_next = push_value;
        occ_next  = 1'b1;
      end
    end else if (cmd.pop_back) begin
      if (last) begin
        occ_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ----- rtl/dq_gather.sv -----
// Registered OR tree that picks the one flagged word out of the cell row.
module dq_gather #(
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 load,
  input  logic [DEPTH-1:0][dq_pkg::DATA_W-1:0] leaf,
  output logic [dq_pkg::DATA_W-1:0]            root
);
  import dq_pkg::*;

  localparam int LEVELS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEAVES = 1 << LEVELS;
  localparam int NODES  = 2 * LEAVES - 1;

  logic [DATA_W-1:0] node [NODES];

  genvar i, k;
  generate
    for (i = 0; i < LEAVES; i++) begin : g_leaf
      if (i < DEPTH) begin : g_real
        always_ff @(posedge clk) begin
          if (load) begin
            node[LEAVES-1+i] <= leaf[i];
          end
        end
      end else begin : g_pad
        always_ff @(posedge clk) begin
          if (load) begin
            node[LEAVES-1+i] <= '0;
          end
        end
      end
    end
    // one level per cycle toward the root
    for (k = 0; k < LEAVES - 1; k++) begin : g_node
      always_ff @(posedge clk) begin
        node[k] <= node[2*k+1] | node[2*k+2];
      end
    end
  endgenerate

  assign root = node[0];

endmodule

// ----- rtl/double_ended_queue.sv -----
// Top level of the bounded double-ended queue of signed 32-bit values.
//
// Input channel (in_valid / in_stall, op, value): one beat is one operation,
// push front, pop front, push back or pop back. Output channel (out_valid /
// out_stall): one beat per operation with status, popped_valid,
// popped_value and occupancy after the operation.
//
// Storage is a row of DEPTH cells, front entry always in cell 0. A front
// push or pop shifts the whole row by one; a back push fills the first
// empty cell, a back pop empties the last full one.
// Pushes, front pops and refused operations build their result at the beat
// and stream at one per cycle while in_stall is low. A successful back pop
// reads the last cell through a registered OR tree of clog2(DEPTH) levels;
// in_stall stays high until the tree has delivered the popped value.
// Results pass through an output register and a skid register; a new beat
// is taken while one result waits. in_stall rises while the skid holds a
// second one or while a back pop is in flight. A held result never changes
// while out_stall is high.
// Reset (rst, synchronous) empties the queue and drops any pending result.
module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       op,
  input  logic signed [dq_pkg::DATA_W-1:0] value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic                             popped_valid,
  output logic signed [dq_pkg::DATA_W-1:0] popped_value,
  output logic [dq_pkg::OCC_W-1:0]         occupancy
);
  import dq_pkg::*;

  localparam int LEVELS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int GW     = $clog2(LEVELS + 1);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_GATHER = 2'b10
  } state_t;

  state_t state, state_next;
  logic [GW-1:0] gcnt, gcnt_next;
  logic [CW-1:0] count, count_next;
  logic [31:0]   count_ext;

  logic [DEPTH-1:0][DATA_W-1:0] cell_data;
  logic [DEPTH-1:0][DATA_W-1:0] leaf;
  logic [DEPTH-1:0]             cell_occ;
  logic [DEPTH-1:0]             cell_last;
  logic [DATA_W-1:0]            value_u;
  logic [DATA_W-1:0]            root;

  logic    accept, full, empty, gather_done, res_valid, take;
  dq_op_t  op_e;
  dq_cmd_t cmd;
  dq_res_t res, out_res, skid_res;
  logic    skid_valid;

  assign value_u = $unsigned(value);
  assign op_e    = dq_op_t'(op);
  assign full    = cell_occ[DEPTH-1];
  assign empty   = !cell_occ[0];

  // skid full means two results waiting; gather means a back pop in flight
  assign in_stall = (state != S_IDLE) || skid_valid;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd            = '0;
    cmd.push_front = accept && (op_e == OP_PUSH_FRONT) && !full;
    cmd.pop_front  = accept && (op_e == OP_POP_FRONT)  && !empty;
    cmd.push_back  = accept && (op_e == OP_PUSH_BACK)  && !full;
    cmd.pop_back   = accept && (op_e == OP_POP_BACK)   && !empty;
  end

  // --- cell row ---
  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] l_data, r_data;
      logic              l_occ, r_occ;
      if (i == 0) begin : g_head
        // front push takes the new value; back push into empty lands here
        assign l_data = value_u;
        assign l_occ  = 1'b1;
      end else begin : g_mid_l
        assign l_data = cell_data[i-1];
        assign l_occ  = cell_occ[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
        assign r_data = '0;
        assign r_occ  = 1'b0;
      end else begin : g_mid_r
        assign r_data = cell_data[i+1];
        assign r_occ  = cell_occ[i+1];
      end

      dq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .cmd        (cmd),
        .push_value (value_u),
        .left_data  (l_data),
        .left_occ   (l_occ),
        .right_data (r_data),
        .right_occ  (r_occ),
        .data       (cell_data[i]),
        .occ        (cell_occ[i]),
        .last       (cell_last[i])
      );

      assign leaf[i] = cell_data[i] & {DATA_W{cell_last[i]}};
    end
  endgenerate

  // back pop: the masked row is latched at the beat, then ORed toward the root
  dq_gather #(.DEPTH(DEPTH)) u_gather (
    .clk  (clk),
    .load (cmd.pop_back),
    .leaf (leaf),
    .root (root)
  );

  // --- occupancy counter ---
  always_comb begin
    count_next = count;
    if (cmd.push_front || cmd.push_back) begin
      count_next = count + CW'(1);
    end else if (cmd.pop_front || cmd.pop_back) begin
      count_next = count - CW'(1);
    end
  end

  // --- sequencer ---
  assign gather_done = (state == S_GATHER) && (gcnt == GW'(LEVELS));

  always_comb begin
    state_next = state;
    gcnt_next  = gcnt;
    unique case (state)
      S_IDLE: begin
        if (cmd.pop_back) begin
          state_next = S_GATHER;
          gcnt_next  = '0;
        end
      end
      S_GATHER: begin
        if (gather_done) begin
          state_next = S_IDLE;
        end else begin
          gcnt_next = gcnt + GW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      gcnt  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      gcnt  <= gcnt_next;
      count <= count_next;
    end
  end

  // --- result build ---
  assign count_ext = 32'(count_next);

  always_comb begin
    res              = '0;
    res.status       = ST_DONE;
    res.occupancy    = count_ext[OCC_W-1:0];
    res_valid        = 1'b0;
    if (gather_done) begin
      res_valid        = 1'b1;
      res.popped_valid = 1'b1;
      res.popped_value = root;
    end else if (accept) begin
      unique case (op_e)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          res_valid = 1'b1;
          if (full) begin
            res.status = ST_FULL;
          end
        end
        OP_POP_FRONT: begin
          res_valid = 1'b1;
          if (empty) begin
            res.status = ST_EMPTY;
          end else begin
            res.popped_valid = 1'b1;
            res.popped_value = cell_data[0];
          end
        end
        OP_POP_BACK: begin
          // a good back pop reports when the tree is done
          res_valid = empty;
          if (empty) begin
            res.status = ST_EMPTY;
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  // --- output register and skid ---
  assign take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res_valid) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      if (!out_valid || take) begin
        out_res <= res;
      end else begin
        skid_res <= res;
      end
    end else if (take && skid_valid) begin
      out_res <= skid_res;
    end
  end

  assign status       = out_res.status;
  assign popped_valid = out_res.popped_valid;
  assign popped_value = $signed(out_res.popped_value);
  assign occupancy    = out_res.occupancy;

  // --- checks ---
  a_count_matches_row: assert property (@(posedge clk) disable iff (rst)
    32'(count) == $countones(cell_occ))
    else $error("occupancy counter disagrees with cell row");

  a_single_back: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_last))
    else $error("more than one cell flagged as back");

  a_back_pop_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_back |=> in_stall)
    else $error("input taken while back pop result is gathered");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result with output register empty");

endmodule
